@@ rtl/ewse_pkg.sv @@
// Package for the encoder window speed estimator.
// Holds word types, field widths, register indexes and reset values.
// Used by the top-level module; depends on nothing.
package ewse_pkg;

    localparam int DEFAULT_WINDOW_TICKS = 5;
    localparam int DEFAULT_NUM_ENCODERS = 2;

    localparam int STAMP_W = 32;
    localparam int DIST_W  = 20;
    localparam int SPAN_CFG_W = 20;
    localparam int SPEED_W = 20;
    localparam int CFG_W   = 20;
    localparam int CFG_IDX_W = 1;

    // Distance in micrometers times 1000 gives a dividend that fits in 30 bits.
    localparam int DIST_SCALE = 1000;
    localparam int SCALE_W    = 10;
    localparam int DIV_W      = DIST_W + SCALE_W;
    localparam int DIV_CNT_W  = $clog2(DIV_W + 1);

    localparam int SPEED_MAX = 1000000;

    localparam logic [DIST_W-1:0]     RESET_WINDOW_DISTANCE = DIST_W'(102102);
    localparam logic [SPAN_CFG_W-1:0] RESET_MIN_SPAN        = SPAN_CFG_W'(10000);

    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_DISTANCE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_SPAN        = 1'b1;

    typedef struct packed {
        logic               side;
        logic [STAMP_W-1:0] edge_time_us;
    } edge_word_t;

    typedef struct packed {
        logic               side_out;
        logic [SPEED_W-1:0] speed_mm_per_s;
        logic               below_min_span;
    } speed_word_t;

endpackage

@@ rtl/ewse_ram.sv @@
// Generic simple dual-port RAM: one write port and one read port with
// registered read data. No dependencies.
module ewse_ram #(
    parameter int WIDTH  = 32,
    parameter int DEPTH  = 10,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ rtl/encoder_window_speed_estimator_unit.sv @@
// Encoder window speed estimator, top level.
// Depends on ewse_pkg and on ewse_ram for the timestamp rings.
//
// Usage: each word on the edge channel is one rising encoder edge, tagged
// with its side and a free-running 32-bit microsecond timestamp. For every
// edge exactly one word leaves on the speed channel: the side, the speed in
// mm/s from the oldest stamp in that side's ring to this edge, and a flag
// set when the window span is under min_span_us (speed then reads zero).
// Both channels use valid/stall; a word moves when valid is high and stall
// is low. Registers are written through cfg_we/cfg_index/cfg_data; the user
// must write them only while the block is idle, which the block does not enforce.
// Processing: an accepted edge passes through the ring read, the span check,
// bit-serial restoring division of the 30-bit dividend, retiring one
// quotient bit per cycle, and final saturation into the output register.
// Words decided at the span check (span under min_span_us, or a zero span,
// which reads SPEED_MAX) skip the division; words whose side is not below
// NUM_ENCODERS go straight out with zero speed. One edge is processed at a time.
// Reset clears all rings (through per-entry valid bits) and pointers and
// loads the register defaults. A finished word waits in the output register
// while the next edge is accepted; if the receiver still stalls when that
// edge finishes, the block holds it and stalls the edge channel.
module encoder_window_speed_estimator_unit
    import ewse_pkg::*;
#(
    parameter int WINDOW_TICKS = DEFAULT_WINDOW_TICKS,
    parameter int NUM_ENCODERS = DEFAULT_NUM_ENCODERS
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 edge_valid,
    output logic                 edge_stall,
    input  edge_word_t           edge_word,
    output logic                 speed_valid,
    input  logic                 speed_stall,
    output speed_word_t          speed_word,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    localparam int DEPTH      = NUM_ENCODERS * WINDOW_TICKS;
    localparam int ADDR_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int PTR_W      = $clog2(WINDOW_TICKS);
    localparam int SIDE_IDX_W = (NUM_ENCODERS > 1) ? $clog2(NUM_ENCODERS) : 1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_CHECK,
        ST_DIV,
        ST_DONE
    } state_t;

    state_t                  state_reg;
    logic [DIST_W-1:0]       dist_reg;
    logic [SPAN_CFG_W-1:0]   min_span_reg;
    logic [PTR_W-1:0]        ptr_reg [NUM_ENCODERS];
    logic [DEPTH-1:0]        ring_valid_reg;
    logic                    side_reg;
    logic [STAMP_W-1:0]      stamp_reg;
    logic                    old_valid_reg;
    logic [STAMP_W-1:0]      span_reg;
    logic [STAMP_W-1:0]      rem_reg;
    logic [DIV_W-1:0]        quo_reg;
    logic [DIV_CNT_W-1:0]    cnt_reg;
    logic                    flag_reg;
    logic                    speed_valid_reg;
    speed_word_t             speed_word_reg;

    logic                    accept;
    logic                    side_in_range;
    logic [SIDE_IDX_W-1:0]   side_idx;
    logic [PTR_W-1:0]        wr_ptr;
    logic [PTR_W-1:0]        old_ptr;
    logic [ADDR_W-1:0]       base_addr;
    logic [ADDR_W-1:0]       wr_addr;
    logic [ADDR_W-1:0]       rd_addr;
    logic                    ring_we;
    logic [STAMP_W-1:0]      ram_rdata;
    logic [STAMP_W-1:0]      old_stamp;
    logic [STAMP_W:0]        shifted;
    logic [STAMP_W+1:0]      trial;
    logic                    trial_ok;
    logic [SPEED_W-1:0]      speed_sat;

    assign accept        = edge_valid && !edge_stall;
    assign edge_stall    = (state_reg != ST_IDLE);
    assign side_in_range = (32'(edge_word.side) < NUM_ENCODERS);
    assign side_idx      = side_in_range ? SIDE_IDX_W'(edge_word.side) : '0;
    assign wr_ptr        = ptr_reg[side_idx];
    assign old_ptr       = (32'(wr_ptr) == WINDOW_TICKS - 1) ? '0 : wr_ptr + PTR_W'(1);
    // Only side one ever needs a nonzero base, and then the depth holds it.
    assign base_addr     = (side_in_range && edge_word.side) ? ADDR_W'(WINDOW_TICKS) : '0;
    assign wr_addr       = base_addr + ADDR_W'(wr_ptr);
    assign rd_addr       = base_addr + ADDR_W'(old_ptr);
    assign ring_we       = accept && side_in_range;

    ewse_ram #(
        .WIDTH  (STAMP_W),
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_ring (
        .clk   (clk),
        .we    (ring_we),
        .waddr (wr_addr),
        .wdata (edge_word.edge_time_us),
        .raddr (rd_addr),
        .rdata (ram_rdata)
    );

    // A ring entry never written since reset reads as zero.
    assign old_stamp = old_valid_reg ? ram_rdata : '0;

    // One step of restoring division: bring down the next dividend bit.
    assign shifted  = {rem_reg, quo_reg[DIV_W-1]};
    assign trial    = {1'b0, shifted} - {2'b00, span_reg};
    assign trial_ok = !trial[STAMP_W+1];

    assign speed_sat = (quo_reg > DIV_W'(SPEED_MAX)) ? SPEED_W'(SPEED_MAX)
                                                     : quo_reg[SPEED_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            dist_reg        <= RESET_WINDOW_DISTANCE;
            min_span_reg    <= RESET_MIN_SPAN;
            ring_valid_reg  <= '0;
            speed_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_ENCODERS; i++)
            begin
                ptr_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_WINDOW_DISTANCE: dist_reg     <= cfg_data[DIST_W-1:0];
                    REG_MIN_SPAN:        min_span_reg <= cfg_data[SPAN_CFG_W-1:0];
                endcase
            end

            // In ST_DONE the output register is reloaded below instead.
            if (speed_valid_reg && !speed_stall && state_reg != ST_DONE)
            begin
                speed_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        side_reg  <= edge_word.side;
                        stamp_reg <= edge_word.edge_time_us;
                        if (side_in_range)
                        begin
                            old_valid_reg           <= ring_valid_reg[rd_addr];
                            ring_valid_reg[wr_addr] <= 1'b1;
                            ptr_reg[side_idx]       <= old_ptr;
                            state_reg               <= ST_READ;
                        end
                        else
                        begin
                            quo_reg   <= '0;
                            flag_reg  <= 1'b0;
                            state_reg <= ST_DONE;
                        end
                    end
                end
                ST_READ:
                begin
                    span_reg  <= stamp_reg - old_stamp;
                    state_reg <= ST_CHECK;
                end
                ST_CHECK:
                begin
                    if (span_reg < STAMP_W'(min_span_reg))
                    begin
                        quo_reg   <= '0;
                        flag_reg  <= 1'b1;
                        state_reg <= ST_DONE;
                    end
                    else if (span_reg == '0)
                    begin
                        quo_reg   <= DIV_W'(SPEED_MAX);
                        flag_reg  <= 1'b0;
                        state_reg <= ST_DONE;
                    end
                    else
                    begin
                        rem_reg   <= '0;
                        quo_reg   <= DIV_W'(dist_reg) * DIV_W'(DIST_SCALE);
                        cnt_reg   <= DIV_CNT_W'(DIV_W);
                        flag_reg  <= 1'b0;
                        state_reg <= ST_DIV;
                    end
                end
                ST_DIV:
                begin
                    rem_reg <= trial_ok ? trial[STAMP_W-1:0] : shifted[STAMP_W-1:0];
                    quo_reg <= {quo_reg[DIV_W-2:0], trial_ok};
                    cnt_reg <= cnt_reg - DIV_CNT_W'(1);
                    if (cnt_reg == DIV_CNT_W'(1))
                    begin
                        state_reg <= ST_DONE;
                    end
                end
                ST_DONE:
                begin
                    if (!speed_valid_reg || !speed_stall)
                    begin
                        speed_word_reg.side_out       <= side_reg;
                        speed_word_reg.speed_mm_per_s <= speed_sat;
                        speed_word_reg.below_min_span <= flag_reg;
                        speed_valid_reg               <= 1'b1;
                        state_reg                     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign speed_valid = speed_valid_reg;
    assign speed_word  = speed_word_reg;

endmodule
